// ----- rtl/bm_pkg.sv -----
// Shared types and constants for the 3x3 binary morphology block.
// No dependencies; bm_stage and binary_morphology_3x3 import this package.
package bm_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int PIXEL_W     = 8;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE   = 2'd2;

   // operation codes; the last one behaves as open
   localparam logic [1:0] MODE_DILATE   = 2'd0;
   localparam logic [1:0] MODE_ERODE    = 2'd1;
   localparam logic [1:0] MODE_OPEN     = 2'd2;
   localparam logic [1:0] MODE_OPEN_ALT = 2'd3;

   // static per-stage control, changes only with a register write
   typedef struct packed {
      logic clear;      // restart stream position, flush pipeline
      logic erode;      // all-set window instead of any-set
      logic deep;       // frame restart follows the next stage's center
      logic emit_tail;  // also pass on results past the last row
   } bm_ctrl_type;

   typedef struct packed {
      logic pixel;
      logic last;
   } bm_item_type;

   typedef struct packed {
      logic win_busy;   // window register holds an item not yet moved out
      logic in_tail;    // stream position is past the last image pixel
   } bm_stat_type;

endpackage

// ----- rtl/bm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module bm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/bm_stage.sv -----
// One 3x3 window stage: stream position counter, two-row line store in bm_ram,
// tap registers and a result register. Depends on bm_pkg and bm_ram.
module bm_stage #(
   parameter int MAX_WIDTH  = bm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bm_pkg::bm_ctrl_type               ctrl,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   img_height,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_filler,
   input  logic                              in_bit,
   output logic                              out_valid,
   input  logic                              out_ready,
   output bm_pkg::bm_item_type               out_item,
   output bm_pkg::bm_stat_type               stat
);
   import bm_pkg::*;

   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int RB  = $clog2(MAX_HEIGHT + 4);
   localparam int SRW = RB + 1;
   localparam logic signed [SRW-1:0] S_ONE = SRW'(1);
   localparam logic signed [SRW-1:0] S_TWO = SRW'(2);

   logic [CB-1:0] col_ff, col_in, col_adv, col_c, col_d, w_m1;
   logic [RB-1:0] row_ff, row_in, row_adv;
   logic signed [SRW-1:0] h_s, h_m1_s, row_s, row_c, row_d;
   logic tail, take, live, bit_set, end_hit, emit, is_last, in_img, move;

   logic [1:0] ram_q, line_q, wr_data, byp_data_ff, byp_data_in;
   logic       byp_ff, byp_in;

   logic [2:0] x_ff, x_in, a_ff, a_in, b_ff, b_in;

   logic                  win_valid_ff, win_valid_in;
   logic signed [SRW-1:0] win_row_ff, win_row_in;
   logic [CB-1:0]         win_col_ff, win_col_in;
   logic                  win_img_ff, win_img_in, win_last_ff, win_last_in;

   logic        out_valid_ff, out_valid_in;
   bm_item_type out_item_ff, out_item_in;

   logic       top_ok, bot_ok, left_ok, right_ok, dil, ero, res;
   logic [2:0] col_ok;
   logic [8:0] taps, tap_ok;

   // position bookkeeping
   always_comb begin
      w_m1   = CB'(img_width - WB'(1));
      h_s    = signed'(SRW'(img_height));
      h_m1_s = h_s - S_ONE;
      row_s  = signed'(SRW'(row_ff));
      tail   = row_ff >= RB'(img_height);

      // window center lags the incoming item by width + 1
      if (col_ff == '0) begin
         col_c = w_m1;
         row_c = row_s - S_TWO;
      end else begin
         col_c = col_ff - CB'(1);
         row_c = row_s - S_ONE;
      end
      // center of the following stage, one more span behind
      if (col_c == '0) begin
         col_d = w_m1;
         row_d = row_c - S_TWO;
      end else begin
         col_d = col_c - CB'(1);
         row_d = row_c - S_ONE;
      end

      is_last = (row_c == h_m1_s) && (col_c == w_m1);
      end_hit = ctrl.deep ? ((row_d == h_m1_s) && (col_d == w_m1)) : is_last;
      in_img  = !row_c[SRW-1] && (row_c < h_s);
      emit    = !row_c[SRW-1] && (in_img || ctrl.emit_tail);

      move     = win_valid_ff && (!out_valid_ff || out_ready);
      in_ready = !win_valid_ff || move;
      take     = in_valid && in_ready;
      // a filler before the last pixel is dropped without touching state
      live     = take && !(in_filler && !tail);
      bit_set  = in_bit && !tail;

      if (col_ff == w_m1) begin
         col_adv = '0;
         row_adv = row_ff + RB'(1);
      end else begin
         col_adv = col_ff + CB'(1);
         row_adv = row_ff;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.clear) begin
         col_in = '0;
         row_in = '0;
      end else if (live) begin
         col_in = end_hit ? '0 : col_adv;
         row_in = end_hit ? '0 : row_adv;
      end
   end

   // line store: entry per column holds {row above, two rows above}
   always_comb begin
      line_q      = byp_ff ? byp_data_ff : ram_q;
      wr_data     = {bit_set, line_q[1]};
      byp_in      = live && !ctrl.clear && (col_in == col_ff);
      byp_data_in = wr_data;
   end

   bm_ram #(
      .WIDTH(2),
      .DEPTH(MAX_WIDTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (live),
      .wr_addr(col_ff),
      .wr_data(wr_data),
      .rd_addr(col_in),
      .rd_data(ram_q)
   );

   // taps and window register
   always_comb begin
      x_in        = x_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      win_row_in  = win_row_ff;
      win_col_in  = win_col_ff;
      win_img_in  = win_img_ff;
      win_last_in = win_last_ff;
      win_valid_in = win_valid_ff && !move;
      if (live) begin
         x_in        = {x_ff[1:0], bit_set};
         a_in        = {a_ff[1:0], line_q[1]};
         b_in        = {b_ff[1:0], line_q[0]};
         win_row_in  = row_c;
         win_col_in  = col_c;
         win_img_in  = in_img;
         win_last_in = is_last;
         win_valid_in = emit;
      end
      if (ctrl.clear) begin
         win_valid_in = 1'b0;
      end
   end

   // 3x3 evaluation; bit 0 of each tap row is the right-hand column
   always_comb begin
      top_ok   = win_row_ff >= S_ONE;
      bot_ok   = win_row_ff < h_m1_s;
      left_ok  = win_col_ff != '0;
      right_ok = win_col_ff != w_m1;
      col_ok   = {left_ok, 1'b1, right_ok};
      taps     = {b_ff, a_ff, x_ff};
      tap_ok   = {col_ok & {3{top_ok}}, col_ok, col_ok & {3{bot_ok}}};
      dil      = |(taps & tap_ok);
      ero      = &(taps | ~tap_ok);
      res      = win_img_ff && (ctrl.erode ? ero : dil);

      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (move) begin
         out_valid_in      = 1'b1;
         out_item_in.pixel = res;
         out_item_in.last  = win_last_ff;
      end
      if (ctrl.clear) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         byp_ff       <= 1'b0;
         win_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         byp_ff       <= byp_in;
         win_valid_ff <= win_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      x_ff        <= x_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      win_row_ff  <= win_row_in;
      win_col_ff  <= win_col_in;
      win_img_ff  <= win_img_in;
      win_last_ff <= win_last_in;
      out_item_ff <= out_item_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_item      = out_item_ff;
   assign stat.win_busy = win_valid_ff;
   assign stat.in_tail  = tail;

endmodule

// ----- rtl/binary_morphology_3x3.sv -----
// 3x3 binary morphology (dilate, erode, open) on a raster pixel stream.
// Top level: csr registers and two bm_stage instances. Depends on bm_pkg and bm_stage.
//
// Usage:
//  - req_ channel: one pixel byte per transaction, nonzero means set. After the last
//    pixel of a frame, send items with req_filler high to push out the tail; fillers
//    sent while pixels are still due are consumed and ignored.
//  - rsp_ channel: one result bit per image pixel in raster order, rsp_frame_end on the
//    last one. The next frame starts with the item after the one that released it.
//  - csr_ channel: index 0 width, 1 height, 2 mode; always ready. A write to one of these
//    restarts the stream position. Write only while no transaction is in flight.
//  - Throughput: one transaction per cycle on both sides while rsp_ready stays high.
//    The result for pixel p leaves after item p + width + 1 is accepted (p + 2*width + 2
//    for open), two register stages per window stage behind that item.
//  - Each stage keeps two image rows in a RAM of MAX_WIDTH entries; neighbors outside
//    the image are masked, so the RAM contents need no clearing after reset.
//  - Reset: width 640, height 480, dilate, empty pipeline.
//  - When rsp_ready is low, the result register and the window register fill, then
//    req_ready drops; nothing is lost.
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH  = bm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bm_pkg::PIXEL_W-1:0]       req_pixel_value,
   input  logic                             req_filler,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_out_pixel,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bm_pkg::*;

   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

   logic [WB-1:0] width_ff, width_in, width_eff;
   logic [HB-1:0] height_ff, height_in, height_eff;
   logic [1:0]    mode_ff, mode_in;
   logic          csr_write, clear, two_stage;

   bm_ctrl_type ctrl1, ctrl2;
   bm_item_type s1_item, s2_item;
   bm_stat_type s1_stat, s2_stat;
   logic        s1_out_valid, s1_out_ready, s2_in_valid, s2_in_ready, s2_out_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sizes are stored already clamped to 1..MAX
   always_comb begin
      if (csr_wdata == '0) begin
         width_eff  = WB'(1);
         height_eff = HB'(1);
      end else begin
         width_eff  = (32'(csr_wdata) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(csr_wdata);
         height_eff = (32'(csr_wdata) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(csr_wdata);
      end

      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      clear     = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH: begin
               width_in = width_eff;
               clear    = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = height_eff;
               clear     = 1'b1;
            end
            REG_MODE: begin
               mode_in = csr_wdata[1:0];
               clear   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(W_RST);
         height_ff <= HB'(H_RST);
         mode_ff   <= MODE_DILATE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   assign two_stage = (mode_ff == MODE_OPEN) || (mode_ff == MODE_OPEN_ALT);

   always_comb begin
      ctrl1.clear     = clear;
      ctrl1.erode     = (mode_ff == MODE_ERODE) || two_stage;
      ctrl1.deep      = two_stage;
      ctrl1.emit_tail = two_stage;
      ctrl2.clear     = clear;
      ctrl2.erode     = 1'b0;
      ctrl2.deep      = 1'b0;
      ctrl2.emit_tail = 1'b0;
   end

   bm_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl1),
      .img_width (width_ff),
      .img_height(height_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_filler (req_filler),
      .in_bit    (|req_pixel_value),
      .out_valid (s1_out_valid),
      .out_ready (s1_out_ready),
      .out_item  (s1_item),
      .stat      (s1_stat)
   );

   // second stage only sees traffic in open mode
   assign s2_in_valid  = two_stage && s1_out_valid;
   assign s1_out_ready = two_stage ? s2_in_ready : rsp_ready;

   bm_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl2),
      .img_width (width_ff),
      .img_height(height_ff),
      .in_valid  (s2_in_valid),
      .in_ready  (s2_in_ready),
      .in_filler (1'b0),
      .in_bit    (s1_item.pixel),
      .out_valid (s2_out_valid),
      .out_ready (rsp_ready),
      .out_item  (s2_item),
      .stat      (s2_stat)
   );

   assign rsp_valid     = two_stage ? s2_out_valid : s1_out_valid;
   assign rsp_out_pixel = two_stage ? s2_item.pixel : s1_item.pixel;
   assign rsp_frame_end = two_stage ? s2_item.last : s1_item.last;

   // input only stalls when both the window and result registers are occupied
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_stat.win_busy && s1_out_valid)
      else $error("input stalled with room in stage one");

   // second stage stays empty and out of its tail outside open mode
   a_stage2_idle: assert property (@(posedge clock) disable iff (reset)
      !two_stage |-> !s2_stat.win_busy && !s2_out_valid && !s2_stat.in_tail)
      else $error("second stage active outside open mode");

endmodule
